FILE: sv/per_user_lru_exclude_set_core_defines.svh
// Assertion macros for the exclusion set block
`ifndef PER_USER_LRU_EXCLUDE_SET_CORE_DEFINES_SVH
`define PER_USER_LRU_EXCLUDE_SET_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/ple_pkg.sv
package ple_pkg;

	localparam int USERS_DEF   = 16;
	localparam int ENTRIES_DEF = 16;

	localparam int UID_W     = 16;
	localparam int DAT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int PSIZE_W   = 5;

	// request modes
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_PURGE = 2'd2;
	localparam logic [1:0] MODE_TICK  = 2'd3;

	// response status codes
	localparam logic [1:0] STAT_ADDED   = 2'd0;
	localparam logic [1:0] STAT_PRESENT = 2'd1;
	localparam logic [1:0] STAT_DONE    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PSIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_READ,
		ST_MOD,
		ST_PREAD,
		ST_PWRITE,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic look;
		logic rd;
		logic modify;
		logic prd;
		logic pwr;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       need_mem;
		logic       cache_on;
		logic       plast;
	} sts_t;

endpackage

FILE: sv/ple_if.sv
interface ple_req_if;
	import ple_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic [UID_W-1:0]        user_id;
	logic signed [DAT_W-1:0] sat;
	logic signed [DAT_W-1:0] sat_key;
	modport source (output valid, mode, user_id, sat, sat_key, input ready);
	modport sink (input valid, mode, user_id, sat, sat_key, output ready);
endinterface

interface ple_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       found;
	modport source (output valid, status, found, input ready);
	modport sink (input valid, status, found, output ready);
endinterface

interface ple_cfg_if;
	import ple_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DAT_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/ple_ctrl.sv
module ple_ctrl
	import ple_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign req_ready = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				case (sts.mode)
					MODE_PURGE: state_d = sts.cache_on ? ST_PREAD : ST_DONE;
					MODE_TICK:  state_d = ST_DONE;
					default:    state_d = sts.need_mem ? ST_READ : ST_DONE;
				endcase
			end
			ST_READ:   state_d = ST_MOD;
			ST_MOD:    state_d = ST_DONE;
			ST_PREAD:  state_d = ST_PWRITE;
			ST_PWRITE: state_d = sts.plast ? ST_DONE : ST_PREAD;
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load = req_valid;
			ST_LOOK:   cmd.look = 1'b1;
			ST_READ:   cmd.rd = 1'b1;
			ST_MOD:    cmd.modify = 1'b1;
			ST_PREAD:  cmd.prd = 1'b1;
			ST_PWRITE: cmd.pwr = 1'b1;
			ST_DONE:   cmd.out_load = slot_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/ple_dp.sv
module ple_dp
	import ple_pkg::*;
#(
	parameter int USERS   = USERS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [1:0]           in_mode,
	input  logic [UID_W-1:0]     in_user_id,
	input  logic [DAT_W-1:0]     in_sat,
	input  logic [DAT_W-1:0]     in_sat_key,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DAT_W-1:0]     cfg_data,
	output logic [1:0]           out_status,
	output logic                 out_found
);

	localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0] AGE_LAST = AW'(ENTRIES - 1);
	localparam logic [UW-1:0] U_LAST   = UW'(USERS - 1);

	typedef struct packed {
		logic             v;
		logic [DAT_W-1:0] s;
		logic [DAT_W-1:0] k;
		logic [AW-1:0]    age;
	} ent_t;

	typedef ent_t [ENTRIES-1:0] row_t;

	// configuration
	logic               enable_q;
	logic [PSIZE_W-1:0] psize_q;
	logic [DAT_W-1:0]   timeout_q;
	logic [DAT_W-1:0]   now_q;

	// latched request
	logic [1:0]       mode_q;
	logic [UID_W-1:0] uid_q;
	logic [DAT_W-1:0] sat_q, key_q;

	// client table
	logic [USERS-1:0] cvalid_q;
	logic [UID_W-1:0] cid_q [USERS];
	logic [DAT_W-1:0] clast_q [USERS];

	logic [UW-1:0] cidx_q, pidx_q;
	logic          newc_q;
	logic [1:0]    res_status_q, out_status_q;
	logic          res_found_q, out_found_q;

	// entry rows
	row_t mem [USERS];
	row_t rd_q;

	logic          bypass, hit_any, free_any;
	logic [UW-1:0] hit_idx, free_idx;
	row_t          base, add_row, trim_row;
	logic          e_hit, full, slot_any;
	logic [AW-1:0] e_idx, old_age, slot_idx;
	logic          idle;

	assign bypass = !enable_q || (uid_q == '0);

	// client search
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = USERS - 1; i >= 0; i--) begin
			if (cvalid_q[i] && cid_q[i] == uid_q) begin
				hit_any = 1'b1;
				hit_idx = UW'(i);
			end
			if (!cvalid_q[i]) begin
				free_any = 1'b1;
				free_idx = UW'(i);
			end
		end
	end

	assign sts.mode     = mode_q;
	assign sts.cache_on = enable_q;
	assign sts.need_mem = !bypass && (hit_any || (mode_q == MODE_ADD && free_any));
	assign sts.plast    = (pidx_q == U_LAST);

	// entry search within the client row
	assign base = newc_q ? '0 : rd_q;

	always_comb begin
		e_hit    = 1'b0;
		e_idx    = '0;
		full     = 1'b1;
		for (int e = ENTRIES - 1; e >= 0; e--) begin
			if (base[e].v && base[e].s == sat_q && base[e].k == key_q) begin
				e_hit = 1'b1;
				e_idx = AW'(e);
			end
			if (!base[e].v) full = 1'b0;
		end
		old_age = base[e_idx].age;
	end

	// add: refresh a held entry, or insert as most recent
	always_comb begin
		add_row  = base;
		slot_any = 1'b0;
		slot_idx = '0;
		if (e_hit) begin
			for (int e = 0; e < ENTRIES; e++) begin
				if (base[e].v && base[e].age < old_age) add_row[e].age = base[e].age + 1'b1;
			end
			add_row[e_idx].age = '0;
		end else begin
			// full set drops its least recent entry first
			for (int e = 0; e < ENTRIES; e++) begin
				if (full && base[e].age >= AGE_LAST) add_row[e].v = 1'b0;
			end
			for (int e = ENTRIES - 1; e >= 0; e--) begin
				if (!add_row[e].v) begin
					slot_any = 1'b1;
					slot_idx = AW'(e);
				end
			end
			for (int e = 0; e < ENTRIES; e++) begin
				if (add_row[e].v) add_row[e].age = add_row[e].age + 1'b1;
			end
			if (slot_any) begin
				add_row[slot_idx].v   = 1'b1;
				add_row[slot_idx].s   = sat_q;
				add_row[slot_idx].k   = key_q;
				add_row[slot_idx].age = '0;
			end
		end
	end

	// purge trim
	always_comb begin
		trim_row = rd_q;
		for (int e = 0; e < ENTRIES; e++) begin
			if (9'(rd_q[e].age) >= 9'(psize_q)) trim_row[e].v = 1'b0;
		end
	end

	assign idle = (now_q - clast_q[pidx_q]) > timeout_q;

	// row memory
	always_ff @(posedge clk) begin
		if (cmd.rd) rd_q <= mem[cidx_q];
		else if (cmd.prd) rd_q <= mem[pidx_q];
		if (cmd.modify && mode_q == MODE_ADD) mem[cidx_q] <= add_row;
		else if (cmd.pwr && cvalid_q[pidx_q] && !idle) mem[pidx_q] <= trim_row;
	end

	// client id and last use
	always_ff @(posedge clk) begin
		if (cmd.modify) begin
			cid_q[cidx_q]   <= uid_q;
			clast_q[cidx_q] <= now_q;
		end
	end

	// request, result and index registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			uid_q  <= in_user_id;
			sat_q  <= in_sat;
			key_q  <= in_sat_key;
		end
		if (cmd.look) begin
			cidx_q       <= hit_any ? hit_idx : free_idx;
			newc_q       <= !hit_any;
			pidx_q       <= '0;
			res_status_q <= (mode_q == MODE_ADD) ? STAT_ADDED : STAT_DONE;
			res_found_q  <= 1'b0;
		end
		if (cmd.modify) begin
			if (mode_q == MODE_ADD) res_status_q <= e_hit ? STAT_PRESENT : STAT_ADDED;
			else res_found_q <= e_hit;
		end
		if (cmd.pwr) pidx_q <= pidx_q + 1'b1;
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
		end
	end

	// control state: configuration, time and client valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			psize_q   <= PSIZE_W'(8);
			timeout_q <= DAT_W'(1000);
			now_q     <= '0;
			cvalid_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE:  enable_q <= cfg_data[0];
					REG_PSIZE:   psize_q <= cfg_data[PSIZE_W-1:0];
					REG_TIMEOUT: timeout_q <= cfg_data;
					default:     ;
				endcase
			end
			if (cmd.look && mode_q == MODE_TICK) now_q <= now_q + 1'b1;
			if (cmd.modify) cvalid_q[cidx_q] <= 1'b1;
			if (cmd.pwr && cvalid_q[pidx_q] && idle) cvalid_q[pidx_q] <= 1'b0;
		end
	end

	assign out_status = out_status_q;
	assign out_found  = out_found_q;

endmodule

FILE: sv/per_user_lru_exclude_set_core.sv
// Per-client recency-ordered exclusion sets with idle expiry.
// Channels: req carries one request (mode, user_id, sat, sat_key); rsp returns
// exactly one response (status, found) per request, in order; cfg writes the
// registers cache_enable (0), purge_size (1) and idle_timeout (2), and is
// always ready. Write cfg only while no request is in flight.
// One request is worked on at a time. Add and query go from acceptance
// to response through client search, row read, row update and result. A
// request that needs no row access, and a tick, go from client search
// straight to the result. With the cache on, a purge walks every client
// slot through the single row memory port, a read and a write each.
// Reset clears the client table, time and configuration to their defaults;
// the row memory needs no clearing, a new client starts with an empty row.
// The response sits in an output register: the next request is accepted
// while it waits, but completes only once rsp has taken the previous one.
`include "per_user_lru_exclude_set_core_defines.svh"
module per_user_lru_exclude_set_core
	import ple_pkg::*;
#(
	parameter int USERS   = USERS_DEF,
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic    clk,
	input logic    arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp,
	ple_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ple_dp #(
		.USERS   (USERS),
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (req.mode),
		.in_user_id (req.user_id),
		.in_sat     (req.sat),
		.in_sat_key (req.sat_key),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_status (rsp.status),
		.out_found  (rsp.found)
	);

	`PLE_ASSERT(a_one_cmd, clk, arst_n, $onehot0({cmd.look, cmd.rd, cmd.modify, cmd.prd, cmd.pwr, cmd.out_load}), "more than one datapath command")
	`PLE_ASSERT(a_no_b2b, clk, arst_n, (req.valid && req.ready) |=> !req.ready, "request taken while busy")
	`PLE_ASSERT(a_status, clk, arst_n, rsp.valid |-> (rsp.status == STAT_ADDED || rsp.status == STAT_PRESENT || rsp.status == STAT_DONE), "bad response status")
	`PLE_ASSERT(a_found, clk, arst_n, (rsp.valid && rsp.found) |-> rsp.status == STAT_DONE, "found set outside a query")

endmodule
